// ===== src/iswc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort package
// Shared sizes and the structs passed between the top level and the cells.
// ----------------------------------------------------------------------------
package iswc_pkg;

	localparam int MAX_ITEMS  = 64;
	localparam int VAL_W      = 32;
	localparam int CNT_W      = 11;
	localparam int FILL_W     = $clog2(MAX_ITEMS + 1);
	localparam int POS_W      = $clog2(MAX_ITEMS);
	localparam int OUT_DATA_W = 56;
	localparam int IN_DATA_W  = 32;

	typedef struct packed {
		logic                    ins;
		logic                    pop;
		logic signed [VAL_W-1:0] value;
	} cell_ctrl_t;

	typedef struct packed {
		logic                    occ;
		logic signed [VAL_W-1:0] value;
	} cell_data_t;

endpackage

// ===== src/iswc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort cell
// Holds one stored element; takes the new value, the lower neighbor on an
// insert shift, or the upper neighbor while the sorted run drains.
// ----------------------------------------------------------------------------
module iswc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  iswc_pkg::cell_ctrl_t ctrl,
	input  iswc_pkg::cell_data_t lower,
	input  logic                lower_le,
	input  iswc_pkg::cell_data_t upper,
	output iswc_pkg::cell_data_t own,
	output logic                le
);
	import iswc_pkg::*;

	logic                    occ_q;
	logic signed [VAL_W-1:0] value_q;

	assign le        = occ_q && !(ctrl.value < value_q);
	assign own.occ   = occ_q;
	assign own.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.pop) begin
			occ_q <= upper.occ;
		end else if (ctrl.ins) begin
			if (!lower_le) begin
				occ_q <= lower.occ;
			end else if (!le) begin
				occ_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			value_q <= upper.value;
		end else if (ctrl.ins) begin
			if (!lower_le) begin
				value_q <= lower.value;
			end else if (!le) begin
				value_q <= ctrl.value;
			end
		end
	end

endmodule

// ===== src/insertion_sort_with_counters.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort with comparison and movement counters
// Sorts signed 32-bit values in a row of cells and drains them in order.
// ----------------------------------------------------------------------------
// Input stream s_*: one signed value per transfer, s_tlast closes the set.
// A value is inserted in the same cycle it is accepted: every cell compares
// the value with its own element and greater elements move up one cell, so
// one item is taken per cycle while the set is being loaded. Items beyond
// MAX_ITEMS are dropped and raise the overflow flag.
// After the transfer with s_tlast, s_tready drops and the row drains from
// cell 0 on the output stream m_*, one sorted value per cycle, each with the
// comparison and movement totals and the overflow flag; m_tlast marks the
// final element. The first result is valid the cycle after the last input.
// A stall on m_tready holds the row; after the final transfer all totals
// clear and s_tready returns. Reset empties the row and clears the totals
// at once.
// ----------------------------------------------------------------------------
module insertion_sort_with_counters (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [iswc_pkg::IN_DATA_W-1:0]     s_tdata,  // [31:0] value
	input  logic                               s_tlast,  // last
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [iswc_pkg::OUT_DATA_W-1:0]    m_tdata,  // [31:0] sorted_value,
	                                                     // [42:32] comparisons,
	                                                     // [53:43] movements
	output logic                               m_tuser,  // overflow
	output logic                               m_tlast   // end_of_run
);
	import iswc_pkg::*;

	cell_ctrl_t              ctrl;
	cell_data_t              cell_d [MAX_ITEMS];
	logic [MAX_ITEMS-1:0]    le;
	logic [MAX_ITEMS-1:0]    boundary;
	logic                    emit_q;
	logic                    dropped_q;
	logic [FILL_W-1:0]       count_q;
	logic [CNT_W-1:0]        comp_q;
	logic [CNT_W-1:0]        move_q;
	logic [POS_W-1:0]        pos;
	logic [FILL_W-1:0]       greater;
	logic                    stopped;
	logic                    accept;
	logic                    full;
	logic                    out_xfer;
	logic                    run_end;

	assign s_tready = !emit_q;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == FILL_W'(MAX_ITEMS));
	assign m_tvalid = emit_q && cell_d[0].occ;
	assign out_xfer = m_tvalid && m_tready;
	assign run_end  = cell_d[0].occ && !cell_d[1].occ;

	assign ctrl.ins   = accept && !full;
	assign ctrl.pop   = out_xfer;
	assign ctrl.value = s_tdata[VAL_W-1:0];

	genvar gi;
	generate
		for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
			cell_data_t lower_d;
			cell_data_t upper_d;
			logic       lower_le;

			if (gi == 0) begin : g_first
				assign lower_d  = '0;
				assign lower_le = 1'b1;
			end else begin : g_mid
				assign lower_d  = cell_d[gi-1];
				assign lower_le = le[gi-1];
			end

			if (gi == MAX_ITEMS - 1) begin : g_top
				assign upper_d = '0;
			end else begin : g_below
				assign upper_d = cell_d[gi+1];
			end

			assign boundary[gi] = lower_le && !le[gi];

			iswc_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.lower    (lower_d),
				.lower_le (lower_le),
				.upper    (upper_d),
				.own      (cell_d[gi]),
				.le       (le[gi])
			);
		end
	endgenerate

	always_comb begin
		pos = '0;
		for (int i = 0; i < MAX_ITEMS; i++) begin
			if (boundary[i]) begin
				pos = pos | POS_W'(i);
			end
		end
	end

	assign greater = count_q - {1'b0, pos};
	assign stopped = (pos != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q    <= 1'b0;
			dropped_q <= 1'b0;
			count_q   <= '0;
			comp_q    <= '0;
			move_q    <= '0;
		end else if (out_xfer && run_end) begin
			emit_q    <= 1'b0;
			dropped_q <= 1'b0;
			count_q   <= '0;
			comp_q    <= '0;
			move_q    <= '0;
		end else if (accept) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				count_q <= count_q + FILL_W'(1);
				comp_q  <= comp_q + CNT_W'(greater) + CNT_W'(stopped);
				move_q  <= move_q + CNT_W'(greater);
			end
			if (s_tlast) begin
				emit_q <= 1'b1;
			end
		end
	end

	assign m_tdata = {{(OUT_DATA_W - VAL_W - 2 * CNT_W){1'b0}}, move_q, comp_q,
		cell_d[0].value};
	assign m_tuser = dropped_q;
	assign m_tlast = run_end;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Insertion sort with counters - testbench
// Streams sets of signed values into the sorter, predicts the sorted drain
// with its comparison and movement totals and the overflow flag, and checks
// every output transfer field by field under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;

	import iswc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int CNT_MAX     = (1 << CNT_W) - 1;
	localparam int REPORT_MAX  = 10;

	class sort_scoreboard;
		typedef struct {
			logic signed [VAL_W-1:0] value;
			logic [CNT_W-1:0]        comps;
			logic [CNT_W-1:0]        moves;
			logic                    overflow;
			logic                    end_of_run;
		} sorted_elem_t;

		logic signed [VAL_W-1:0] shelf [MAX_ITEMS];
		int                      fill;
		int                      comp_total;
		int                      move_total;
		bit                      dropped;
		sorted_elem_t            sorted_q [$];
		int                      mismatches;
		int                      results_seen;
		int                      sets_closed;

		function new();
			fill         = 0;
			comp_total   = 0;
			move_total   = 0;
			dropped      = 0;
			mismatches   = 0;
			results_seen = 0;
			sets_closed  = 0;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= REPORT_MAX) begin
				$display("[%0t] mismatch: %s", $realtime, msg);
			end
		endfunction

		function void take_value(logic signed [VAL_W-1:0] val, bit is_last);
			int           pos;
			int           greater;
			bit           stopped;
			sorted_elem_t e;
			if (fill < MAX_ITEMS) begin
				pos     = fill;
				greater = 0;
				stopped = 0;
				while (pos > 0 && !stopped) begin
					if (val < shelf[pos-1]) begin
						shelf[pos] = shelf[pos-1];
						greater++;
						pos--;
					end else begin
						stopped = 1;
					end
				end
				shelf[pos] = val;
				fill++;
				comp_total += greater + int'(stopped);
				move_total += greater;
				if (comp_total > CNT_MAX) comp_total = CNT_MAX;
				if (move_total > CNT_MAX) move_total = CNT_MAX;
			end else begin
				dropped = 1;
			end
			if (is_last) begin
				for (int k = 0; k < fill; k++) begin
					e.value      = shelf[k];
					e.comps      = comp_total[CNT_W-1:0];
					e.moves      = move_total[CNT_W-1:0];
					e.overflow   = dropped;
					e.end_of_run = (k == fill - 1);
					sorted_q.push_back(e);
				end
				sets_closed++;
				fill       = 0;
				comp_total = 0;
				move_total = 0;
				dropped    = 0;
			end
		endfunction

		function void check_sorted(logic [OUT_DATA_W-1:0] data, logic ovf, logic eor);
			sorted_elem_t e;
			if (sorted_q.size() == 0) begin
				flag($sformatf("unexpected result value %0d", $signed(data[VAL_W-1:0])));
				return;
			end
			e = sorted_q.pop_front();
			results_seen++;
			if (data[VAL_W-1:0] !== e.value)
				flag($sformatf("sorted_value exp %0d got %0d", e.value,
					$signed(data[VAL_W-1:0])));
			if (data[VAL_W +: CNT_W] !== e.comps)
				flag($sformatf("comparisons exp %0d got %0d", e.comps, data[VAL_W +: CNT_W]));
			if (data[VAL_W+CNT_W +: CNT_W] !== e.moves)
				flag($sformatf("movements exp %0d got %0d", e.moves,
					data[VAL_W+CNT_W +: CNT_W]));
			if (data[OUT_DATA_W-1:VAL_W+2*CNT_W] !== '0)
				flag($sformatf("tdata padding exp 0 got %b", data[OUT_DATA_W-1:VAL_W+2*CNT_W]));
			if (ovf !== e.overflow)
				flag($sformatf("overflow exp %0b got %b", e.overflow, ovf));
			if (eor !== e.end_of_run)
				flag($sformatf("end_of_run exp %0b got %b", e.end_of_run, eor));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	sort_scoreboard board;
	int             send_idle_pct;
	int             recv_stall_pct;
	int             cycles;
	int             items_sent;
	int             largest_set;

	insertion_sort_with_counters u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		m_tready = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_sorted(m_tdata, m_tuser, m_tlast);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, board.sorted_q.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_item(input logic signed [VAL_W-1:0] val, input bit is_last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = val;
		s_tlast  = is_last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.take_value(val, is_last);
		items_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_list(input logic signed [VAL_W-1:0] vals [$]);
		foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
		if (vals.size() > largest_set) largest_set = vals.size();
	endtask

	task automatic wait_drained();
		while (board.sorted_q.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		int r;
		r = $urandom_range(9);
		if (r < 5) return $urandom;
		if (r < 8) return $urandom_range(8) - 4;
		case ($urandom_range(4))
			0:       return {1'b1, {(VAL_W-1){1'b0}}};
			1:       return {1'b0, {(VAL_W-1){1'b1}}};
			2:       return '0;
			3:       return '1;
			default: return 1;
		endcase
	endfunction

	task automatic run_small_sets(input int target);
		int                      start;
		int                      size;
		logic signed [VAL_W-1:0] vals [$];
		start = items_sent;
		while (items_sent - start < target) begin
			size = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 1);
			vals.delete();
			repeat (size) vals.push_back(pick_value());
			send_list(vals);
			if ($urandom_range(3) == 0) wait_drained();
		end
	endtask

	task automatic set_phase(input int idle_pct, input int stall_pct);
		wait_drained();
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	initial begin
		logic signed [VAL_W-1:0] vals [$];
		board          = new();
		cycles         = 0;
		items_sent     = 0;
		largest_set    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tlast        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: single-element set, extremes with duplicates, sorted, reversed, all equal
		vals = '{32'sh8000_0000};
		send_list(vals);
		vals = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh7FFF_FFFF, 32'sh8000_0000};
		send_list(vals);
		vals = '{-3, -2, -1, 0, 1, 2};
		send_list(vals);
		vals = '{5, 4, 3, 2, 1};
		send_list(vals);
		vals = '{7, 7, 7, 7};
		send_list(vals);

		// full store in strictly falling order, then two dropped items, the last one closing
		vals.delete();
		for (int i = 0; i < MAX_ITEMS + 2; i++)
			vals.push_back(32'sh7FFF_FFFF - i * (1 << 25) - $urandom_range(1 << 20));
		send_list(vals);

		set_phase(83, 0);
		run_small_sets(20);
		set_phase(0, 83);
		run_small_sets(20);
		set_phase(24, 24);
		run_small_sets(20);

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Sent %0d values in %0d sets (largest %0d, overflow included).",
			items_sent, board.sets_closed, largest_set);
		$display("Checked %0d sorted results across four idle/stall mixes, %0d mismatches.",
			board.results_seen, board.mismatches);
		if (board.mismatches == 0 && board.sorted_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== insertion_sort_with_counters.f =====
src/iswc_pkg.sv
src/iswc_cell.sv
src/insertion_sort_with_counters.sv
test/tb_top.sv
